### src/ctb_pkg.sv
`default_nettype none

package ctb_pkg;

	// Bank size and derived address width.
	localparam int TIMER_COUNT = 16;
	localparam int ADDR_W      = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

	// Field widths.
	localparam int CMD_W    = 3;
	localparam int IDX_W    = 4;
	localparam int PERIOD_W = 16;
	localparam int FREQ_W   = 13;
	localparam int COUNT_W  = 16;
	localparam int STATUS_W = 2;

	// Load value arithmetic: (period * freq * 10 + 5) / 10000.
	localparam int PROD_W     = PERIOD_W + FREQ_W;
	localparam int DIVISOR    = 10000;
	localparam int ROUND_BIAS = 5;

	// The load value equals ((period * freq) >> 3) / 125, and the divide by 125
	// is a multiplication by ceil(2^33 / 125) followed by a shift right by 33,
	// exact for every operand below 2^26.
	localparam int MUL_W       = 27;
	localparam int MULP_W      = 2 * MUL_W;
	localparam int PRE_SHIFT   = 3;
	localparam int RECIP_SHIFT = 33;
	localparam logic [MUL_W-1:0] RECIP_MULT = 27'd68719477;

	localparam logic [FREQ_W-1:0] FREQ_RESET = 13'd1000;

	typedef enum logic [CMD_W-1:0] {
		CMD_START = 3'd0,
		CMD_CLOSE = 3'd1,
		CMD_CHECK = 3'd2,
		CMD_TICK  = 3'd3,
		CMD_CLEAR = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OFF      = 2'd0,
		ST_COUNTING = 2'd1,
		ST_EXPIRED  = 2'd2
	} status_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

### src/ctb_ram.sv
`default_nettype none

module ctb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic                                          re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### src/ctb_div.sv
`default_nettype none

// Computes the low bits of (period * freq * 10 + 5) / 10000 with one shared
// multiplier used twice. Since 10 * x + 5 = 5 * (2 * x + 1) and 2 * x + 1 is
// odd, the quotient equals (x >> 3) / 125, and that divide is done as a
// multiplication by a scaled reciprocal.
module ctb_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [ctb_pkg::PERIOD_W-1:0]   period_ms,
	input  wire logic [ctb_pkg::FREQ_W-1:0]     tick_frequency_hz,
	output ctb_pkg::div_stat_t                  stat,
	output logic      [ctb_pkg::COUNT_W-1:0]    quotient
);

	typedef enum logic [1:0] {
		D_IDLE  = 2'b01,
		D_RECIP = 2'b10
	} dstate_t;

	dstate_t                            state_q;
	logic [ctb_pkg::MULP_W-1:0]         prod_q;
	logic                               done_q;

	logic [ctb_pkg::MUL_W-1:0]          mul_a;
	logic [ctb_pkg::MUL_W-1:0]          mul_b;
	logic [ctb_pkg::MULP_W-1:0]         mul_p;
	logic                               mul_en;

	// First pass multiplies period by rate, the second pass multiplies the
	// scaled product by the reciprocal of 125.
	assign mul_a = (state_q == D_RECIP)
		? ctb_pkg::MUL_W'(prod_q[ctb_pkg::PROD_W-1:ctb_pkg::PRE_SHIFT])
		: ctb_pkg::MUL_W'(period_ms);
	assign mul_b = (state_q == D_RECIP) ? ctb_pkg::RECIP_MULT
		: ctb_pkg::MUL_W'(tick_frequency_hz);
	assign mul_p  = ctb_pkg::MULP_W'(mul_a) * ctb_pkg::MULP_W'(mul_b);
	assign mul_en = ((state_q == D_IDLE) && start) || (state_q == D_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == D_RECIP);
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_RECIP;
					end
				end
				D_RECIP: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_p;
		end
	end

	assign stat.busy = (state_q != D_IDLE);
	assign stat.done = done_q;
	assign quotient  = prod_q[ctb_pkg::RECIP_SHIFT +: ctb_pkg::COUNT_W];

endmodule

`default_nettype wire

### src/countdown_timer_bank.sv
`default_nettype none

// Bank of countdown timers with an enable bit and a 16-bit tick count each.
// Commands arrive as stream transactions on the s_axis group; every command
// produces exactly one result transaction on the m_axis group, holding the
// status (off, counting, expired) and the count of the addressed timer.
// A start loads (period_ms * tick_frequency_hz * 10 + 5) / 10000, low 16 bits.
// The block takes one command at a time and drops s_axis_tready while busy.
// A close, check or clear all goes through a read state and a response
// state before its result reaches the output register; a start first runs
// the shared multiplier twice, and a tick first walks every counter through
// the count memory. The next command is taken once the block is back in idle.
// The output register lets the next command be accepted while a result still
// waits; if the receiver stalls and a second result is ready, the block holds
// it and keeps s_axis_tready low until the register frees.
// The user writes the tick rate register through cfg_wr_en / cfg_wr_data only
// while the block is idle; the block does not enforce it. Reset sets the tick
// rate to 1000 Hz, disables every timer and marks every count as zero through
// per-entry valid bits, so no clearing pass is needed and it is ready at once.
module countdown_timer_bank (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [ctb_pkg::FREQ_W-1:0]    cfg_wr_data,   // tick_frequency_hz
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// [2:0] command, [6:3] timer_index, [22:7] period_ms, [23] zero
	input  wire logic [23:0]                   s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [1:0] status, [17:2] remaining_ticks, [23:18] zero
	output logic      [23:0]                   m_axis_tdata
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DIV   = 5'b00010,
		S_SWEEP = 5'b00100,
		S_READ  = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	localparam int AW = ctb_pkg::ADDR_W;
	localparam int TC = ctb_pkg::TIMER_COUNT;

	state_t                             state_q;
	logic [ctb_pkg::FREQ_W-1:0]         freq_q;
	logic [TC-1:0]                      en_q;
	logic [TC-1:0]                      vld_q;
	logic [ctb_pkg::IDX_W-1:0]          idx_q;
	logic                               idx_ok_q;
	logic [AW:0]                        sweep_q;
	logic                               wb_s1;
	logic [AW-1:0]                      wb_addr_s1;
	logic                               out_valid_q;
	ctb_pkg::status_t                   out_status_q;
	logic [ctb_pkg::COUNT_W-1:0]        out_ticks_q;

	logic                               in_acc;
	ctb_pkg::cmd_t                      in_cmd;
	logic [ctb_pkg::IDX_W-1:0]          in_idx;
	logic [ctb_pkg::PERIOD_W-1:0]       in_period;
	logic                               in_ok;
	logic [AW-1:0]                      in_addr;
	logic [AW-1:0]                      addr;

	logic                               ram_we;
	logic [AW-1:0]                      ram_waddr;
	logic [ctb_pkg::COUNT_W-1:0]        ram_wdata;
	logic                               ram_re;
	logic [AW-1:0]                      ram_raddr;
	logic [ctb_pkg::COUNT_W-1:0]        ram_rdata;

	logic                               sweep_live;
	logic                               div_start;
	ctb_pkg::div_stat_t                 div_stat;
	logic [ctb_pkg::COUNT_W-1:0]        div_quot;

	logic [ctb_pkg::COUNT_W-1:0]        rd_count;
	ctb_pkg::status_t                   rd_status;

	// Input unpacking.
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign in_cmd    = ctb_pkg::cmd_t'(s_axis_tdata[2:0]);
	assign in_idx    = s_axis_tdata[6:3];
	assign in_period = s_axis_tdata[22:7];
	assign in_ok     = ({2'b00, in_idx} < 6'(TC));
	assign in_addr   = AW'(in_idx);
	assign addr      = AW'(idx_q);

	assign s_axis_tready = (state_q == S_IDLE);
	assign div_start     = in_acc && (in_cmd == ctb_pkg::CMD_START);

	ctb_div u_div (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (div_start),
		.period_ms         (in_period),
		.tick_frequency_hz (freq_q),
		.stat              (div_stat),
		.quotient          (div_quot)
	);

	// The tick sweep reads one counter per cycle and in the same cycle writes
	// the previous one back, decremented, unless it is invalid or already zero.
	assign sweep_live = (state_q == S_SWEEP) && (sweep_q < (AW + 1)'(TC));
	assign ram_re     = (state_q == S_READ) || sweep_live;
	assign ram_raddr  = (state_q == S_SWEEP) ? sweep_q[AW-1:0] : addr;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr;
		ram_wdata = div_quot;
		if (state_q == S_DIV) begin
			ram_we = div_stat.done && idx_ok_q;
		end else if (state_q == S_SWEEP) begin
			ram_waddr = wb_addr_s1;
			ram_wdata = ram_rdata - ctb_pkg::COUNT_W'(1);
			ram_we    = wb_s1 && vld_q[wb_addr_s1] && (ram_rdata != '0);
		end
	end

	ctb_ram #(
		.WIDTH (ctb_pkg::COUNT_W),
		.DEPTH (TC)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// A counter that was never written since reset, close or clear all reads
	// as zero.
	always_comb begin
		rd_count  = vld_q[addr] ? ram_rdata : '0;
		rd_status = ctb_pkg::ST_COUNTING;
		if (!idx_ok_q) begin
			rd_count  = '0;
			rd_status = ctb_pkg::ST_OFF;
		end else if (!en_q[addr]) begin
			rd_status = ctb_pkg::ST_OFF;
		end else if (rd_count == '0) begin
			rd_status = ctb_pkg::ST_EXPIRED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= ctb_pkg::FREQ_RESET;
		end else if (cfg_wr_en) begin
			freq_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			en_q        <= '0;
			vld_q       <= '0;
			sweep_q     <= '0;
			wb_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register stays full until taken and is refilled by a
			// pending result as soon as it is free.
			out_valid_q <= (out_valid_q && !m_axis_tready)
				|| (state_q == S_RESP && (!out_valid_q || m_axis_tready));
			wb_s1 <= sweep_live;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (in_cmd)
							ctb_pkg::CMD_START: begin
								state_q <= S_DIV;
							end
							ctb_pkg::CMD_TICK: begin
								sweep_q <= '0;
								state_q <= S_SWEEP;
							end
							ctb_pkg::CMD_CLOSE: begin
								if (in_ok) begin
									en_q[in_addr]  <= 1'b0;
									vld_q[in_addr] <= 1'b0;
								end
								state_q <= S_READ;
							end
							ctb_pkg::CMD_CLEAR: begin
								en_q    <= '0;
								vld_q   <= '0;
								state_q <= S_READ;
							end
							default: begin
								state_q <= S_READ;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (idx_ok_q) begin
							en_q[addr]  <= 1'b1;
							vld_q[addr] <= 1'b1;
						end
						state_q <= S_READ;
					end
				end
				S_SWEEP: begin
					if (sweep_live) begin
						sweep_q <= sweep_q + (AW + 1)'(1);
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q    <= in_idx;
			idx_ok_q <= in_ok;
		end
		if (state_q == S_SWEEP) begin
			wb_addr_s1 <= sweep_q[AW-1:0];
		end
		if (state_q == S_RESP && (!out_valid_q || m_axis_tready)) begin
			out_status_q <= rd_status;
			out_ticks_q  <= rd_count;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b000000, out_ticks_q, out_status_q};

	// A command is worked on alone: nothing is taken in the cycle after one is.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("input accepted back to back");

	// Counts are written only when a start finishes or during a tick sweep.
	a_ram_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_DIV || state_q == S_SWEEP))
		else $error("count memory written outside start or tick");

	// The divider only runs on behalf of a start command.
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == S_DIV))
		else $error("divider busy outside start handling");

	// The sweep never reads the entry it is writing back.
	a_sweep_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("count memory read and written at one address");

	// A finished result waits while the output register is still full.
	a_resp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && out_valid_q && !m_axis_tready) |=> (state_q == S_RESP))
		else $error("result dropped while output stalled");

endmodule

`default_nettype wire
